/* rtl/core/hold_to_ramp_dimmer_unit_macros.svh */
// assertion helpers shared by the ramp dimmer rtl
`ifndef HOLD_TO_RAMP_DIMMER_UNIT_MACROS_SVH
`define HOLD_TO_RAMP_DIMMER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HTRD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ramp dimmer check failed");

// next-cycle implication, checked outside reset
`define HTRD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ramp dimmer check failed");

`endif

/* rtl/core/htrd_pkg.sv */
`default_nettype none

package htrd_pkg;

   localparam logic [7:0]  STEP_DIVIDER    = 8'd4;
   localparam logic [12:0] SINGLE_CELL_CAP = 13'd1800;
   localparam logic [5:0]  IDLE_SAVE_TICKS = 6'd32;
   localparam logic [2:0]  BLINK_TICKS     = 3'd4;
   localparam logic [12:0] FLOOR_BLINK_MA  = 13'd30;

   localparam logic [12:0] RESET_CEILING = 13'd1800;
   localparam logic [12:0] RESET_FLOOR   = 13'd550;
   localparam logic [12:0] RESET_RATED   = 13'd3000;
   localparam logic [12:0] RESET_LEVEL   = 13'd550;

   // operation codes
   localparam logic [1:0] OP_KEY_SAMPLE = 2'd0;
   localparam logic [1:0] OP_TICK       = 2'd1;
   localparam logic [1:0] OP_ENTER      = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DUAL_CELL_MODE     = 2'd0;
   localparam logic [1:0] CSR_RAMP_CEILING       = 2'd1;
   localparam logic [1:0] CSR_RAMP_FLOOR         = 2'd2;
   localparam logic [1:0] CSR_MODE_RATED_CURRENT = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic        key_hold_up;
      logic        key_hold_down;
      logic [12:0] gear_limit;
   } req_type;

   typedef struct packed {
      logic [12:0] drive_current;
      logic        save_request;
      logic        limit_blink;
   } rsp_type;

   typedef struct packed {
      logic        dual_cell_mode;
      logic [12:0] ramp_ceiling;
      logic [12:0] ramp_floor;
      logic [12:0] mode_rated_current;
   } cfg_type;

   // post-update view of the state that shapes the drive current
   typedef struct packed {
      logic [12:0] ramp_level;
      logic [2:0]  blink_timer;
      logic        at_top_flag;
   } view_type;

endpackage

`default_nettype wire

/* rtl/core/htrd_state.sv */
`default_nettype none

`include "hold_to_ramp_dimmer_unit_macros.svh"

module htrd_state
   import htrd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output view_type     view,
   output logic         save_request
);

   logic [12:0] ramp_level_ff, ramp_level_in;
   logic [7:0]  step_divider_ff, step_divider_in;
   logic        key_latched_ff, key_latched_in;
   logic        at_top_flag_ff, at_top_flag_in;
   logic [2:0]  blink_timer_ff, blink_timer_in;
   logic [5:0]  idle_save_timer_ff, idle_save_timer_in;
   logic        wait_release_ff, wait_release_in;

   logic        press;
   logic [12:0] limit_base;
   logic [12:0] limit;
   logic [12:0] level_clamped;
   logic [2:0]  blink_dec;

   assign press      = item.key_hold_up | item.key_hold_down;
   assign limit_base = cfg.dual_cell_mode ? item.gear_limit : SINGLE_CELL_CAP;
   assign limit      = (cfg.ramp_ceiling < limit_base) ? cfg.ramp_ceiling : limit_base;
   // a press snaps an over-limit level down when the limit sits below rated
   assign level_clamped = ((limit < cfg.mode_rated_current) && press && (ramp_level_ff > limit))
                        ? limit : ramp_level_ff;
   assign blink_dec = blink_timer_ff - 3'd1;

   always_comb begin
      ramp_level_in      = ramp_level_ff;
      step_divider_in    = step_divider_ff;
      key_latched_in     = key_latched_ff;
      at_top_flag_in     = at_top_flag_ff;
      blink_timer_in     = blink_timer_ff;
      idle_save_timer_in = idle_save_timer_ff;
      wait_release_in    = wait_release_ff;
      save_request       = 1'b0;

      case (item.operation)
         OP_KEY_SAMPLE: begin
            if (wait_release_ff) begin
               blink_timer_in = 3'd0;
               if (!press) begin
                  wait_release_in = 1'b0;
               end
            end else begin
               ramp_level_in = level_clamped;
               if (item.key_hold_up && !key_latched_ff) begin
                  if (step_divider_ff != 8'd0) begin
                     step_divider_in = step_divider_ff - 8'd1;
                  end else begin
                     if (level_clamped < limit) begin
                        ramp_level_in = level_clamped + 13'd1;
                     end else begin
                        at_top_flag_in = 1'b1;
                        blink_timer_in = BLINK_TICKS;
                        ramp_level_in  = limit;
                        key_latched_in = 1'b1;
                     end
                     step_divider_in = STEP_DIVIDER;
                  end
               end else if (item.key_hold_down && !key_latched_ff) begin
                  if (step_divider_ff != 8'd0) begin
                     step_divider_in = step_divider_ff - 8'd1;
                  end else begin
                     if (level_clamped > cfg.ramp_floor) begin
                        ramp_level_in = level_clamped - 13'd1;
                     end else begin
                        at_top_flag_in = 1'b0;
                        blink_timer_in = BLINK_TICKS;
                        ramp_level_in  = cfg.ramp_floor;
                        key_latched_in = 1'b1;
                     end
                     step_divider_in = STEP_DIVIDER;
                  end
               end else if (!press && key_latched_ff) begin
                  key_latched_in  = 1'b0;
                  step_divider_in = STEP_DIVIDER;
               end

               if (press) begin
                  idle_save_timer_in = IDLE_SAVE_TICKS;
               end else if (idle_save_timer_ff == 6'd1) begin
                  idle_save_timer_in = 6'd0;
                  save_request       = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (idle_save_timer_ff > 6'd1) begin
               idle_save_timer_in = idle_save_timer_ff - 6'd1;
            end
            if (blink_timer_ff != 3'd0) begin
               blink_timer_in = blink_dec;
               if (blink_dec == 3'd0) begin
                  at_top_flag_in = 1'b0;
               end
            end
         end
         OP_ENTER: begin
            wait_release_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign view.ramp_level  = ramp_level_in;
   assign view.blink_timer = blink_timer_in;
   assign view.at_top_flag = at_top_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_level_ff      <= RESET_LEVEL;
         step_divider_ff    <= STEP_DIVIDER;
         key_latched_ff     <= 1'b0;
         at_top_flag_ff     <= 1'b0;
         blink_timer_ff     <= 3'd0;
         idle_save_timer_ff <= 6'd0;
         wait_release_ff    <= 1'b0;
      end else if (step_en) begin
         ramp_level_ff      <= ramp_level_in;
         step_divider_ff    <= step_divider_in;
         key_latched_ff     <= key_latched_in;
         at_top_flag_ff     <= at_top_flag_in;
         blink_timer_ff     <= blink_timer_in;
         idle_save_timer_ff <= idle_save_timer_in;
         wait_release_ff    <= wait_release_in;
      end
   end

   `HTRD_ASSERT_NOW(a_blink_bounded, 1'b1, blink_timer_ff <= BLINK_TICKS)
   `HTRD_ASSERT_NOW(a_idle_bounded, 1'b1, idle_save_timer_ff <= IDLE_SAVE_TICKS)
   `HTRD_ASSERT_NEXT(a_save_clears_idle, step_en && save_request, idle_save_timer_ff == 6'd0)

endmodule

`default_nettype wire

/* rtl/core/htrd_drive.sv */
`default_nettype none

module htrd_drive
   import htrd_pkg::*;
(
   input  wire view_type          view,
   input  wire cfg_type           cfg,
   output logic [12:0]            drive_current,
   output logic                   limit_blink
);

   logic [12:0] capped;
   logic [12:0] shaped;

   assign capped = (view.ramp_level > cfg.ramp_ceiling) ? cfg.ramp_ceiling : view.ramp_level;

   // blink window: quarter current at the ceiling, fixed low current at the floor
   always_comb begin
      shaped = capped;
      if (view.blink_timer != 3'd0) begin
         shaped = view.at_top_flag ? (capped >> 2) : FLOOR_BLINK_MA;
      end
   end

   assign drive_current = (!cfg.dual_cell_mode && (shaped > SINGLE_CELL_CAP))
                        ? SINGLE_CELL_CAP : shaped;
   assign limit_blink   = (view.blink_timer != 3'd0);

endmodule

`default_nettype wire

/* rtl/core/hold_to_ramp_dimmer_unit.sv */
`default_nettype none

`include "hold_to_ramp_dimmer_unit_macros.svh"

// Hold-to-ramp dimmer. Each request (key sample, timer tick or ramp entry)
// produces exactly one response carrying the drive current target, a one-shot
// save request and the limit blink flag. A request is captured in an input
// register; the state update and the output shaping then run as one short
// compare/increment path into the response register. Throughput is one request
// per clock while the response register is not stalled. The only stall is a full
// response register that is not being taken, which holds the input register and
// drops req_ready. Configuration writes are accepted every cycle (csr_ready is
// tied high) and take effect on the next request; they are meant to be issued
// while no request is in flight.
module hold_to_ramp_dimmer_unit
   import htrd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_data
);

   // configuration registers
   cfg_type cfg_ff;

   // input stage
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;

   // response stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic     step_en;
   logic     save_request;
   view_type view;

   // the captured request moves on when the response slot is free or draining
   assign step_en   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || step_en;
   assign csr_ready = 1'b1;

   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !step_en);
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dual_cell_mode     <= 1'b0;
         cfg_ff.ramp_ceiling       <= RESET_CEILING;
         cfg_ff.ramp_floor         <= RESET_FLOOR;
         cfg_ff.mode_rated_current <= RESET_RATED;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DUAL_CELL_MODE:     cfg_ff.dual_cell_mode     <= csr_data[0];
            CSR_RAMP_CEILING:       cfg_ff.ramp_ceiling       <= csr_data;
            CSR_RAMP_FLOOR:         cfg_ff.ramp_floor         <= csr_data;
            CSR_MODE_RATED_CURRENT: cfg_ff.mode_rated_current <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ramp state machine and its update
   htrd_state u_state (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .item         (req_data_ff),
      .cfg          (cfg_ff),
      .view         (view),
      .save_request (save_request)
   );

   // drive current shaping from the updated state
   htrd_drive u_drive (
      .view          (view),
      .cfg           (cfg_ff),
      .drive_current (rsp_data_in.drive_current),
      .limit_blink   (rsp_data_in.limit_blink)
   );

   assign rsp_data_in.save_request = save_request;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a stalled response slot keeps its contents
   `HTRD_ASSERT_NEXT(a_rsp_held, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_data_ff))
   // a captured request is never dropped while stalled
   `HTRD_ASSERT_NEXT(a_req_kept, req_valid_ff && !step_en, req_valid_ff && $stable(req_data_ff))
   // every advance lands in the response slot
   `HTRD_ASSERT_NEXT(a_step_lands, step_en, rsp_valid_ff)

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import htrd_pkg::*;

   // the one operation code the block leaves unused
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // generous bound on the whole run, in clock cycles
   localparam int unsigned CYCLE_LIMIT = 200000;
   // most mismatch lines printed; all of them are counted
   localparam int unsigned PRINT_LIMIT = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;

   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_DUAL_CELL_MODE;
   logic [12:0] csr_data = '0;

   hold_to_ramp_dimmer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predicted dimmer state and register copy, both at reset values
   // ------------------------------------------------------------------
   logic [12:0] ramp_lvl = RESET_LEVEL;
   logic [7:0]  step_cnt = STEP_DIVIDER;
   logic        keys_latched = 1'b0;
   logic        at_top = 1'b0;
   logic [2:0]  blink_left = '0;
   logic [5:0]  idle_left = '0;
   logic        awaiting_release = 1'b0;
   cfg_type     cfg_mirror = '{dual_cell_mode: 1'b0, ramp_ceiling: RESET_CEILING,
                               ramp_floor: RESET_FLOOR, mode_rated_current: RESET_RATED};

   // responses still owed by the block, oldest first
   rsp_type expected_drive_q[$];

   int unsigned items_sent = 0;
   int unsigned regs_written = 0;
   int unsigned responses_checked = 0;
   int unsigned saves_seen = 0;
   int unsigned blinks_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // receiver hold-off length, loaded at a rising edge, counted down at falling edges
   int unsigned hold_off_left = 0;
   // no idling on either side while set
   logic steady_flow = 1'b0;

   // advance the predicted state by one request and shape the response
   function automatic rsp_type dimmer_step(input req_type item);
      logic [12:0] lim;
      logic [12:0] cur;
      logic        press;
      logic        up;
      logic        dn;
      logic        save;
      rsp_type     out;
      up    = item.key_hold_up;
      dn    = item.key_hold_down;
      press = up | dn;
      save  = 1'b0;
      case (item.operation)
         OP_KEY_SAMPLE: begin
            if (awaiting_release) begin
               // entry still waiting: blink cut short, no ramping, no save
               blink_left = '0;
               if (!press)
                  awaiting_release = 1'b0;
            end else begin
               lim = cfg_mirror.dual_cell_mode ? item.gear_limit : SINGLE_CELL_CAP;
               if (cfg_mirror.ramp_ceiling < lim)
                  lim = cfg_mirror.ramp_ceiling;
               // low limit pulls the level down as soon as a key goes down
               if (lim < cfg_mirror.mode_rated_current && press && ramp_lvl > lim)
                  ramp_lvl = lim;
               if (up && !keys_latched) begin
                  if (step_cnt != 0) begin
                     step_cnt = step_cnt - 1'b1;
                  end else begin
                     if (ramp_lvl < lim) begin
                        ramp_lvl = ramp_lvl + 1'b1;
                     end else begin
                        at_top       = 1'b1;
                        blink_left   = BLINK_TICKS;
                        ramp_lvl     = lim;
                        keys_latched = 1'b1;
                     end
                     step_cnt = STEP_DIVIDER;
                  end
               end else if (dn && !keys_latched) begin
                  if (step_cnt != 0) begin
                     step_cnt = step_cnt - 1'b1;
                  end else begin
                     if (ramp_lvl > cfg_mirror.ramp_floor) begin
                        ramp_lvl = ramp_lvl - 1'b1;
                     end else begin
                        at_top       = 1'b0;
                        blink_left   = BLINK_TICKS;
                        ramp_lvl     = cfg_mirror.ramp_floor;
                        keys_latched = 1'b1;
                     end
                     step_cnt = STEP_DIVIDER;
                  end
               end else if (!press && keys_latched) begin
                  keys_latched = 1'b0;
                  step_cnt     = STEP_DIVIDER;
               end
               if (press) begin
                  idle_left = IDLE_SAVE_TICKS;
               end else if (idle_left == 6'd1) begin
                  idle_left = '0;
                  save      = 1'b1;
               end
            end
         end
         OP_TICK: begin
            // idle timer parks at one until the next key sample
            if (idle_left > 6'd1)
               idle_left = idle_left - 1'b1;
            if (blink_left != 0) begin
               blink_left = blink_left - 1'b1;
               if (blink_left == 0)
                  at_top = 1'b0;
            end
         end
         OP_ENTER: awaiting_release = 1'b1;
         default: ;
      endcase
      cur = (ramp_lvl > cfg_mirror.ramp_ceiling) ? cfg_mirror.ramp_ceiling : ramp_lvl;
      if (blink_left != 0)
         cur = at_top ? (cur >> 2) : FLOOR_BLINK_MA;
      if (!cfg_mirror.dual_cell_mode && cur > SINGLE_CELL_CAP)
         cur = SINGLE_CELL_CAP;
      out.drive_current = cur;
      out.save_request  = save;
      out.limit_blink   = (blink_left != 0);
      return out;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at response %0d: %s got %0d want %0d",
                  responses_checked, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // response side: random ready, long hold-offs on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_left != 0) begin
         rsp_ready = 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_ready = steady_flow || ($urandom_range(99) >= 12);
      end
   end

   // compare every accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive_q.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_data.drive_current, 0);
         end else begin
            want = expected_drive_q.pop_front();
            if (rsp_data.drive_current !== want.drive_current)
               report_mismatch("drive_current", rsp_data.drive_current, want.drive_current);
            if (rsp_data.save_request !== want.save_request)
               report_mismatch("save_request", rsp_data.save_request, want.save_request);
            if (rsp_data.limit_blink !== want.limit_blink)
               report_mismatch("limit_blink", rsp_data.limit_blink, want.limit_blink);
         end
         responses_checked++;
         if (rsp_data.save_request === 1'b1)
            saves_seen++;
         if (rsp_data.limit_blink === 1'b1)
            blinks_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses owed",
                  cycle_count, expected_drive_q.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // one request, with an occasional gap ahead of it; starts and ends at a falling edge
   task automatic send_request(input req_type item);
      if (!steady_flow && $urandom_range(99) < 8) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // predict in acceptance order
      expected_drive_q.push_back(dimmer_step(item));
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic offer_request(input logic [1:0] op, input logic up, input logic dn,
                                input logic [12:0] gear);
      req_type item;
      item.operation     = op;
      item.key_hold_up   = up;
      item.key_hold_down = dn;
      item.gear_limit    = gear;
      send_request(item);
   endtask

   // fully random request, unused operation code included
   task automatic offer_noise();
      offer_request(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    13'($urandom_range(0, 4100)));
   endtask

   // wait for every owed response, then let the pipeline settle
   task automatic drain_pipeline();
      while (expected_drive_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_register(input logic [1:0] index, input logic [12:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         CSR_DUAL_CELL_MODE:     cfg_mirror.dual_cell_mode     = value[0];
         CSR_RAMP_CEILING:       cfg_mirror.ramp_ceiling       = value;
         CSR_RAMP_FLOOR:         cfg_mirror.ramp_floor         = value;
         CSR_MODE_RATED_CURRENT: cfg_mirror.mode_rated_current = value;
         default: ;
      endcase
      regs_written++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // rewrite all four registers once the block has gone quiet
   task automatic program_config(input logic dual, input logic [12:0] ceiling,
                                 input logic [12:0] floor_ma, input logic [12:0] rated);
      drain_pipeline();
      program_register(CSR_DUAL_CELL_MODE, {12'd0, dual});
      program_register(CSR_RAMP_CEILING, ceiling);
      program_register(CSR_RAMP_FLOOR, floor_ma);
      program_register(CSR_MODE_RATED_CURRENT, rated);
   endtask

   // mostly well-formed key activity: holds, releases, idle runs toward a save,
   // ramp entries with the key still down, and a little noise
   task automatic play_sequences(input int unsigned n_items);
      int unsigned first;
      int unsigned pick;
      int unsigned g;
      logic        up;
      logic        dn;
      logic [12:0] gear;
      first = items_sent;
      while (items_sent - first < n_items) begin
         // gear limit mostly just above the level so dual-cell limits get hit
         case ($urandom_range(9))
            0: gear = 13'd0;
            1: gear = 13'd4100;
            2, 3: gear = 13'($urandom_range(0, 4100));
            default: begin
               g = ramp_lvl + $urandom_range(0, 30);
               gear = (g > 4100) ? 13'd4100 : 13'(g);
            end
         endcase
         pick = $urandom_range(99);
         if (pick < 45) begin
            // hold up, down or both, with ticks in between
            case ($urandom_range(2))
               0: {up, dn} = 2'b10;
               1: {up, dn} = 2'b01;
               default: {up, dn} = 2'b11;
            endcase
            repeat ($urandom_range(5, 60))
               offer_request(($urandom_range(99) < 15) ? OP_TICK : OP_KEY_SAMPLE, up, dn, gear);
         end else if (pick < 65) begin
            // keys released, unlatching
            repeat ($urandom_range(1, 6))
               offer_request(($urandom_range(99) < 30) ? OP_TICK : OP_KEY_SAMPLE,
                             1'b0, 1'b0, gear);
         end else if (pick < 77) begin
            // idle long enough, or just short, for the save pulse
            repeat ($urandom_range(29, 33))
               offer_request(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), gear);
            repeat ($urandom_range(1, 2))
               offer_request(OP_KEY_SAMPLE, 1'b0, 1'b0, gear);
         end else if (pick < 87) begin
            // enter ramp while a key is still held, then let go
            {up, dn} = 2'($urandom_range(1, 3));
            offer_request(OP_ENTER, up, dn, gear);
            repeat ($urandom_range(0, 4))
               offer_request(OP_KEY_SAMPLE, up, dn, gear);
            repeat ($urandom_range(1, 3))
               offer_request(OP_KEY_SAMPLE, 1'b0, 1'b0, gear);
         end else begin
            repeat ($urandom_range(1, 6))
               offer_noise();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_directed_cases();
      // unused operation leaves reset state alone
      offer_request(OP_UNUSED, 1'b1, 1'b1, 13'd4100);
      offer_request(OP_KEY_SAMPLE, 1'b0, 1'b0, 13'd0);
      offer_request(OP_TICK, 1'b0, 1'b0, 13'd0);
      // both keys: up wins, one step after the divider runs out
      repeat (5)
         offer_request(OP_KEY_SAMPLE, 1'b1, 1'b1, 13'd4100);
      // entry waits for release before ramping again
      offer_request(OP_ENTER, 1'b1, 1'b0, 13'd0);
      offer_request(OP_KEY_SAMPLE, 1'b1, 1'b0, 13'd0);
      offer_request(OP_KEY_SAMPLE, 1'b0, 1'b0, 13'd0);
      // ceiling one step away: climb, then latch at the top with quarter current
      drain_pipeline();
      program_register(CSR_RAMP_CEILING, ramp_lvl + 13'd1);
      repeat (10)
         offer_request(OP_KEY_SAMPLE, 1'b1, 1'b0, 13'd4100);
      offer_request(OP_TICK, 1'b1, 1'b0, 13'd4100);
      offer_request(OP_KEY_SAMPLE, 1'b0, 1'b0, 13'd4100);
   endtask

   // register corners, each followed by a short burst of key activity
   task automatic test_register_extremes();
      program_config(1'b0, 13'd0, 13'd0, 13'd0);
      play_sequences(40);
      program_config(1'b1, 13'd4100, 13'd4100, 13'd4100);
      play_sequences(40);
      program_config(1'b1, 13'd4100, 13'd0, 13'd0);
      play_sequences(40);
      program_config(1'b0, 13'd4100, 13'd0, 13'd4100);
      play_sequences(40);
      program_config(1'b1, 13'd0, 13'd4100, 13'd4100);
      play_sequences(40);
      program_config(1'b0, RESET_CEILING, RESET_FLOOR, RESET_RATED);
      play_sequences(40);
   endtask

   // narrow floor-to-ceiling windows around the present level so both limits get hit
   task automatic test_ramp_windows();
      int lo;
      int hi;
      for (int phase = 0; phase < 6; phase++) begin
         drain_pipeline();
         lo = int'(ramp_lvl) - int'($urandom_range(0, 25));
         hi = int'(ramp_lvl) + int'($urandom_range(0, 25));
         if (lo < 0)
            lo = 0;
         if (hi > 4100)
            hi = 4100;
         program_config(1'($urandom_range(1)), 13'(hi), 13'(lo),
                        13'($urandom_range(0, 4100)));
         // one phase runs flat out with no idling on either side
         steady_flow = (phase == 3);
         play_sequences(70);
         steady_flow = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      // long receiver hold-off while requests keep coming
      @(posedge clock);
      hold_off_left = 200;
      @(negedge clock);
      play_sequences(70);
      // sender stops until every response is back
      drain_pipeline();
      play_sequences(40);
   endtask

   task automatic test_noise();
      repeat (120)
         offer_noise();
      play_sequences(30);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_ramp_windows();
      test_backpressure();
      test_noise();

      drain_pipeline();
      repeat (8) @(negedge clock);
      if (expected_drive_q.size() != 0)
         report_mismatch("responses never returned", 0, expected_drive_q.size());

      $display("testbench: %0d requests, %0d responses checked, %0d register writes",
               items_sent, responses_checked, regs_written);
      $display("testbench: %0d save pulses and %0d limit blink responses seen",
               saves_seen, blinks_seen);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
